[design/multi_key_click_classifier_core_assert.svh]
// assertion macros for the multi-key click classifier
// expects clk and rst_n in the scope where a macro is used
`ifndef MULTI_KEY_CLICK_CLASSIFIER_CORE_ASSERT_SVH
`define MULTI_KEY_CLICK_CLASSIFIER_CORE_ASSERT_SVH

// property checked at every edge outside reset
`define MKCC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define MKCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/mkcc_pkg.sv]
// shared types and constants of the multi-key click classifier
// no dependencies
`default_nettype none

package mkcc_pkg;

    // per-key machine phases
    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_PRESS_DB  = 3'd1,
        PH_PRESSED   = 3'd2,
        PH_REL_DB    = 3'd3,
        PH_WAIT2     = 3'd4,
        PH_PRESS2_DB = 3'd5,
        PH_PRESSED2  = 3'd6,
        PH_REL2_DB   = 3'd7
    } key_phase_t;

    // event kinds reported per tick
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_CLICK  = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } ev_kind_t;

    // register indexes of the configuration port
    localparam logic [2:0] CFG_KEY_COUNT    = 3'd0;
    localparam logic [2:0] CFG_DEBOUNCE     = 3'd1;
    localparam logic [2:0] CFG_LONG_PRESS   = 3'd2;
    localparam logic [2:0] CFG_DOUBLE_CLICK = 3'd3;

    localparam int LEVEL_W = 16;
    localparam int TICK_W  = 16;

    // stored state of one key
    typedef struct packed {
        key_phase_t          phase;
        logic [TICK_W-1:0]   stable_count;
        logic [TICK_W-1:0]   hold_count;
        logic [TICK_W-1:0]   window_count;
        logic                long_sent;
    } key_state_t;

    localparam int KEY_STATE_W = $bits(key_state_t);

    // thresholds the step unit works against
    typedef struct packed {
        logic [TICK_W-1:0] deb_limit;
        logic [TICK_W-1:0] long_limit;
        logic [TICK_W-1:0] dbl_limit;
    } tick_cfg_t;

endpackage

`default_nettype wire

[design/mkcc_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module mkcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/mkcc_key_step.sv]
// step unit: advances one key's machine by one scan tick
// depends on mkcc_pkg
`default_nettype none

module mkcc_key_step (
    input  wire mkcc_pkg::key_state_t state_in,
    input  wire logic                 down,
    input  wire mkcc_pkg::tick_cfg_t  cfg,
    output mkcc_pkg::key_state_t      state_out,
    output mkcc_pkg::ev_kind_t        event_kind
);
    import mkcc_pkg::*;

    logic [TICK_W-1:0] stable_inc;
    logic [TICK_W-1:0] hold_inc;
    logic [TICK_W-1:0] window_inc;
    logic              deb_done;

    // saturating counters and debounce compare
    assign stable_inc = (&state_in.stable_count) ? state_in.stable_count
                                                 : state_in.stable_count + 1'b1;
    assign hold_inc   = (&state_in.hold_count) ? state_in.hold_count
                                               : state_in.hold_count + 1'b1;
    assign window_inc = (&state_in.window_count) ? state_in.window_count
                                                 : state_in.window_count + 1'b1;
    assign deb_done   = (stable_inc >= cfg.deb_limit);

    // phase transitions
    always_comb
    begin
        state_out  = state_in;
        event_kind = EV_NONE;
        unique case (state_in.phase)
            PH_IDLE:
            begin
                if (down)
                begin
                    state_out.stable_count = '0;
                    state_out.phase        = PH_PRESS_DB;
                end
            end
            PH_PRESS_DB:
            begin
                if (down)
                begin
                    state_out.stable_count = stable_inc;
                    if (deb_done)
                    begin
                        state_out.hold_count = '0;
                        state_out.long_sent  = 1'b0;
                        state_out.phase      = PH_PRESSED;
                    end
                end
                else
                begin
                    state_out.phase = PH_IDLE;
                end
            end
            PH_PRESSED:
            begin
                if (down)
                begin
                    state_out.hold_count = hold_inc;
                    if ((cfg.long_limit != '0) && !state_in.long_sent &&
                        (hold_inc >= cfg.long_limit))
                    begin
                        event_kind          = EV_LONG;
                        state_out.long_sent = 1'b1;
                    end
                end
                else
                begin
                    state_out.stable_count = '0;
                    state_out.phase        = PH_REL_DB;
                end
            end
            PH_REL_DB:
            begin
                if (!down)
                begin
                    state_out.stable_count = stable_inc;
                    if (deb_done)
                    begin
                        if (state_in.long_sent)
                        begin
                            state_out = '0;
                        end
                        else if (cfg.dbl_limit == '0)
                        begin
                            event_kind = EV_CLICK;
                            state_out  = '0;
                        end
                        else
                        begin
                            state_out.window_count = '0;
                            state_out.phase        = PH_WAIT2;
                        end
                    end
                end
                else
                begin
                    // bounce back to held, hold count and long flag kept
                    state_out.phase = PH_PRESSED;
                end
            end
            PH_WAIT2:
            begin
                if (down)
                begin
                    state_out.stable_count = '0;
                    state_out.phase        = PH_PRESS2_DB;
                end
                else
                begin
                    state_out.window_count = window_inc;
                    if (window_inc >= cfg.dbl_limit)
                    begin
                        event_kind = EV_CLICK;
                        state_out  = '0;
                    end
                end
            end
            PH_PRESS2_DB:
            begin
                if (down)
                begin
                    state_out.stable_count = stable_inc;
                    if (deb_done)
                    begin
                        state_out.phase = PH_PRESSED2;
                    end
                end
                else
                begin
                    state_out.phase = PH_WAIT2;
                end
            end
            PH_PRESSED2:
            begin
                if (!down)
                begin
                    state_out.stable_count = '0;
                    state_out.phase        = PH_REL2_DB;
                end
            end
            PH_REL2_DB:
            begin
                if (!down)
                begin
                    state_out.stable_count = stable_inc;
                    if (deb_done)
                    begin
                        event_kind = EV_DOUBLE;
                        state_out  = '0;
                    end
                end
                else
                begin
                    state_out.phase = PH_PRESSED2;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

[design/multi_key_click_classifier_core.sv]
// top level of the multi-key click classifier: sequencer, key state ram, event capture
// depends on mkcc_pkg, mkcc_ram, mkcc_key_step and the assertion macro header
//
//   channel  direction  signals                          carries
//   s_*      in         s_tvalid s_tready s_tdata[15:0]  key_levels
//   m_*      out        m_tvalid m_tready m_tdata[7:0]   event_key
//                       m_tuser[1:0]                     event_kind
//   cfg_*    in         cfg_valid cfg_ready cfg_index    register writes
//                       cfg_data[15:0]
//
// a tick's result is registered n + 1 cycles after accept, n = min(key_count, MAX_KEYS)
// the single step unit visits one key per cycle, fed by the key state ram read port
// s_tready is high only between ticks, so a tick is taken at most every n + 2 cycles
// a new tick may be taken while a result waits; a waiting result holds the sequencer
// in its final cycle
// reset clears per-key valid flags, so every key reads as idle with no clearing pass
`default_nettype none

`include "multi_key_click_classifier_core_assert.svh"

module multi_key_click_classifier_core #(
    parameter int MAX_KEYS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // key_levels [15:0]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,
    // event_key [3:0], zero fill [7:4]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,
    // event_kind [1:0]
    output logic [1:0]       m_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import mkcc_pkg::*;

    localparam int KEY_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CNT_W = $clog2(MAX_KEYS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } seq_state_t;

    seq_state_t           state_reg, state_next;
    logic [KEY_W-1:0]     cur_reg, cur_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [LEVEL_W-1:0]   levels_reg, levels_next;
    logic [MAX_KEYS-1:0]  valid_reg, valid_next;
    logic [3:0]           ev_key_reg, ev_key_next;
    ev_kind_t             ev_kind_reg, ev_kind_next;
    logic                 m_valid_reg, m_valid_next;
    logic [3:0]           m_key_reg, m_key_next;
    ev_kind_t             m_kind_reg, m_kind_next;
    logic [4:0]           key_count_reg, key_count_next;
    tick_cfg_t            cfg_reg, cfg_next;

    logic                 in_accept;
    logic [CNT_W-1:0]     n_clip;
    logic                 last_key;
    logic [31:0]          cur_wide;
    logic                 down;
    logic                 ram_re;
    logic [KEY_W-1:0]     ram_raddr;
    logic                 ram_we;
    logic [KEY_STATE_W-1:0] ram_rdata;
    key_state_t           key_cur;
    key_state_t           key_upd;
    ev_kind_t             step_ev;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // keys scanned this tick, clipped to the store depth
    assign n_clip = (32'(key_count_reg) > MAX_KEYS) ? CNT_W'(MAX_KEYS)
                                                    : CNT_W'(key_count_reg);
    assign last_key = ((CNT_W'(cur_reg) + 1'b1) == n_reg);

    // level of the current key; keys past the input width read as released
    assign cur_wide = 32'(cur_reg);
    assign down     = (cur_wide < LEVEL_W) && levels_reg[cur_wide[3:0]];

    // read key 0 on accept, then one key ahead while stepping
    assign ram_re    = in_accept || ((state_reg == S_RUN) && !last_key);
    assign ram_raddr = (state_reg == S_RUN) ? cur_reg + 1'b1 : '0;
    assign ram_we    = (state_reg == S_RUN);

    mkcc_ram #(
        .WIDTH (KEY_STATE_W),
        .DEPTH (MAX_KEYS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cur_reg),
        .wdata (key_upd),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // entries never written since reset read as idle
    assign key_cur = valid_reg[cur_reg] ? key_state_t'(ram_rdata) : '0;

    mkcc_key_step u_step (
        .state_in   (key_cur),
        .down       (down),
        .cfg        (cfg_reg),
        .state_out  (key_upd),
        .event_kind (step_ev)
    );

    // sequencer, event capture, output register and configuration
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        n_next         = n_reg;
        levels_next    = levels_reg;
        valid_next     = valid_reg;
        ev_key_next    = ev_key_reg;
        ev_kind_next   = ev_kind_reg;
        m_valid_next   = m_valid_reg;
        m_key_next     = m_key_reg;
        m_kind_next    = m_kind_reg;
        key_count_next = key_count_reg;
        cfg_next       = cfg_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    levels_next  = s_tdata;
                    n_next       = n_clip;
                    cur_next     = '0;
                    ev_key_next  = '0;
                    ev_kind_next = EV_NONE;
                    state_next   = (n_clip == '0) ? S_DONE : S_RUN;
                end
            end
            S_RUN:
            begin
                // only the first event of the tick is kept
                if ((ev_kind_reg == EV_NONE) && (step_ev != EV_NONE))
                begin
                    ev_key_next  = cur_wide[3:0];
                    ev_kind_next = step_ev;
                end
                valid_next[cur_reg] = 1'b1;
                if (last_key)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cur_next = cur_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_key_next   = ev_key_reg;
                    m_kind_next  = ev_kind_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_KEY_COUNT:    key_count_next     = cfg_data[4:0];
                CFG_DEBOUNCE:     cfg_next.deb_limit  = cfg_data;
                CFG_LONG_PRESS:   cfg_next.long_limit = cfg_data;
                CFG_DOUBLE_CLICK: cfg_next.dbl_limit  = cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            n_reg         <= '0;
            valid_reg     <= '0;
            ev_key_reg    <= '0;
            ev_kind_reg   <= EV_NONE;
            m_valid_reg   <= 1'b0;
            m_key_reg     <= '0;
            m_kind_reg    <= EV_NONE;
            key_count_reg <= 5'd16;
            cfg_reg       <= '{deb_limit: 16'd20, long_limit: '0, dbl_limit: '0};
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            n_reg         <= n_next;
            valid_reg     <= valid_next;
            ev_key_reg    <= ev_key_next;
            ev_kind_reg   <= ev_kind_next;
            m_valid_reg   <= m_valid_next;
            m_key_reg     <= m_key_next;
            m_kind_reg    <= m_kind_next;
            key_count_reg <= key_count_next;
            cfg_reg       <= cfg_next;
        end
    end

    // tick levels carry no reset
    always_ff @(posedge clk)
    begin
        levels_reg <= levels_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_key_reg};
    assign m_tuser  = m_kind_reg;

    // checks
    `MKCC_ASSERT(a_cur_in_range, (state_reg != S_RUN) || (CNT_W'(cur_reg) < n_reg),
        "key index beyond scanned count")
    `MKCC_ASSERT(a_none_key_zero, !m_tvalid || (m_tuser != EV_NONE) || (m_tdata == 8'd0),
        "event key not zero on a none result")
    `MKCC_ASSERT_NEXT(a_first_event_held, (state_reg == S_RUN) && (ev_kind_reg != EV_NONE),
        $stable(ev_kind_reg) && $stable(ev_key_reg), "first event of tick overwritten")
    `MKCC_ASSERT_NEXT(a_result_waits, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "waiting result changed")

endmodule

`default_nettype wire
